// ===== sv/twr_pkg.sv =====
// package for the three-wire serial bus master: codes, state and step types
// no dependencies; used by the step logic and the top level
package twr_pkg;

  // number of data bytes in a burst transaction (1..8)
  localparam int unsigned BURST_BYTES = 8;

  // command codes carried in the request cmd field
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_SREAD  = 3'd1;
  localparam logic [2:0] CMD_SWRITE = 3'd2;
  localparam logic [2:0] CMD_BREAD  = 3'd3;
  localparam logic [2:0] CMD_BWRITE = 3'd4;

  // fixed command bytes for burst transactions
  localparam logic [7:0] BURST_READ_BYTE  = 8'hBF;
  localparam logic [7:0] BURST_WRITE_BYTE = 8'hBE;

  // running transaction kind
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SREAD  = 3'd1,
    MODE_SWRITE = 3'd2,
    MODE_BREAD  = 3'd3,
    MODE_BWRITE = 3'd4
  } mode_e;

  // bus master state carried from tick to tick
  typedef struct packed {
    mode_e       mode;
    logic        half_phase;
    logic [2:0]  bit_count;
    logic [3:0]  byte_count;
    logic [7:0]  shift_byte;
    logic [63:0] data_buffer;
  } state_t;

  // one request: a half-bit tick
  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  addr;
    logic [63:0] wdata;
    logic        io_in;
  } req_t;

  // pin levels and status produced by one tick
  typedef struct packed {
    logic        chip_enable;
    logic        serial_clock;
    logic        io_out;
    logic        io_drive;
    logic        busy_res;
    logic        done_res;
    logic [63:0] rdata;
  } res_t;

endpackage

// ===== sv/twr_req_if.sv =====
// request channel: valid/ready handshake carrying one half-bit tick
// depends on nothing
interface twr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [4:0]  addr;
  logic [63:0] wdata;
  logic        io_in;

  modport source (output valid, output cmd, output addr, output wdata, output io_in,
                  input ready);
  modport sink   (input valid, input cmd, input addr, input wdata, input io_in,
                  output ready);
endinterface

// ===== sv/twr_res_if.sv =====
// result channel: valid/ready handshake carrying pin levels and status
// depends on nothing
interface twr_res_if;
  logic        valid;
  logic        ready;
  logic        chip_enable;
  logic        serial_clock;
  logic        io_out;
  logic        io_drive;
  logic        busy_res;
  logic        done_res;
  logic [63:0] rdata;

  modport source (output valid, output chip_enable, output serial_clock, output io_out,
                  output io_drive, output busy_res, output done_res, output rdata,
                  input ready);
  modport sink   (input valid, input chip_enable, input serial_clock, input io_out,
                  input io_drive, input busy_res, input done_res, input rdata,
                  output ready);
endinterface

// ===== sv/twr_step.sv =====
// next-state and output logic for one half-bit tick of the bus master
// depends on twr_pkg
module twr_step (
  input  twr_pkg::state_t state_i,
  input  twr_pkg::req_t   req_i,
  output twr_pkg::state_t state_o,
  output twr_pkg::res_t   res_o
);

  twr_pkg::state_t s;
  twr_pkg::res_t   r;
  logic            is_burst;
  logic            is_write;
  logic            writing;
  logic [3:0]      n_bytes;
  logic [3:0]      next_byte;
  logic [2:0]      rd_idx;
  logic [2:0]      wr_idx;

  always_comb begin
    s = state_i;
    r = '0;

    // start a transaction when idle
    if (s.mode == twr_pkg::MODE_IDLE) begin
      s.half_phase = 1'b0;
      s.bit_count  = '0;
      s.byte_count = '0;
      unique case (req_i.cmd)
        twr_pkg::CMD_SREAD: begin
          s.mode        = twr_pkg::MODE_SREAD;
          s.shift_byte  = {2'b10, req_i.addr, 1'b1};
          s.data_buffer = '0;
        end
        twr_pkg::CMD_SWRITE: begin
          s.mode        = twr_pkg::MODE_SWRITE;
          s.shift_byte  = {2'b10, req_i.addr, 1'b0};
          s.data_buffer = {56'd0, req_i.wdata[7:0]};
        end
        twr_pkg::CMD_BREAD: begin
          s.mode        = twr_pkg::MODE_BREAD;
          s.shift_byte  = twr_pkg::BURST_READ_BYTE;
          s.data_buffer = '0;
        end
        twr_pkg::CMD_BWRITE: begin
          s.mode        = twr_pkg::MODE_BWRITE;
          s.shift_byte  = twr_pkg::BURST_WRITE_BYTE;
          s.data_buffer = req_i.wdata;
        end
        default: begin
          s = state_i;
        end
      endcase
    end

    is_burst  = (s.mode == twr_pkg::MODE_BREAD) || (s.mode == twr_pkg::MODE_BWRITE);
    is_write  = (s.mode == twr_pkg::MODE_SWRITE) || (s.mode == twr_pkg::MODE_BWRITE);
    n_bytes   = is_burst ? 4'(twr_pkg::BURST_BYTES) : 4'd1;
    writing   = (s.byte_count == 4'd0) || is_write;
    next_byte = 4'(s.byte_count + 4'd1);
    rd_idx    = 3'(s.byte_count - 4'd1);
    wr_idx    = 3'(next_byte - 4'd1);

    // run the transaction
    if (s.mode != twr_pkg::MODE_IDLE) begin
      r.busy_res = 1'b1;
      if (s.byte_count > n_bytes) begin
        // done tick: report read data (zero on a write) and go idle
        r.done_res = 1'b1;
        r.rdata    = is_write ? 64'd0 : s.data_buffer;
        s          = '0;
      end else begin
        r.chip_enable = 1'b1;
        if (!s.half_phase) begin
          // low half: drive a written bit or sample a read bit
          if (writing) begin
            r.io_out   = s.shift_byte[0];
            r.io_drive = 1'b1;
          end else if (req_i.io_in) begin
            s.shift_byte[s.bit_count] = 1'b1;
          end
          s.half_phase = 1'b1;
        end else begin
          // high half: clock high, shift out, advance bit and byte
          r.serial_clock = 1'b1;
          if (writing) begin
            r.io_out     = s.shift_byte[0];
            r.io_drive   = 1'b1;
            s.shift_byte = {1'b0, s.shift_byte[7:1]};
          end
          s.half_phase = 1'b0;
          if (s.bit_count == 3'd7) begin
            s.bit_count = '0;
            if (!writing) begin
              s.data_buffer[{rd_idx, 3'b000} +: 8] = s.shift_byte;
            end
            s.byte_count = next_byte;
            if (is_write && (next_byte <= n_bytes)) begin
              s.shift_byte = s.data_buffer[{wr_idx, 3'b000} +: 8];
            end else begin
              s.shift_byte = '0;
            end
          end else begin
            s.bit_count = 3'(s.bit_count + 3'd1);
          end
        end
      end
    end

    state_o = s;
    res_o   = r;
  end

endmodule

// ===== sv/three_wire_rtc_bus_master_core.sv =====
// top level of the three-wire serial bus master: request register, state, result register
// depends on twr_pkg, twr_req_if, twr_res_if and twr_step
//
// Each request is one half-bit tick of the serial bus and yields exactly one
// result with the pin levels (chip enable, clock, data out, drive enable) and
// status for that tick. A request is taken every cycle: it is captured in a
// request register, the step logic computes the next bus state and the pin
// levels combinationally, and they land in the result register, so a result is
// valid once its request has passed both registers and can be taken at the
// next clock edge. While a result waits to be taken the step stops; the
// request register still takes one more request if it is empty, and once it
// is full the request side stalls until the waiting result is taken. A
// command that arrives while a transaction runs is ignored; a transaction
// takes 16 ticks per byte plus one done tick, the done tick pulsing done_res
// with the read data on rdata.
module three_wire_rtc_bus_master_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  twr_req_if.sink       in_i,
  twr_res_if.source     out_o
);

  logic            req_valid_q;
  twr_pkg::req_t   req_q;
  logic            res_valid_q;
  twr_pkg::res_t   res_q;
  twr_pkg::state_t state_q;
  twr_pkg::state_t state_d;
  twr_pkg::res_t   res_d;
  logic            step_en;

  // a waiting request is processed as a tick when the result register is free or drains this cycle
  assign step_en  = req_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !req_valid_q || step_en;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      req_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      req_q <= '{cmd: in_i.cmd, addr: in_i.addr, wdata: in_i.wdata, io_in: in_i.io_in};
    end
  end

  // tick logic
  twr_step u_step (
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // bus master state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_en) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step_en) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res_d;
    end
  end

  // result channel
  assign out_o.valid        = res_valid_q;
  assign out_o.chip_enable  = res_q.chip_enable;
  assign out_o.serial_clock = res_q.serial_clock;
  assign out_o.io_out       = res_q.io_out;
  assign out_o.io_drive     = res_q.io_drive;
  assign out_o.busy_res     = res_q.busy_res;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.rdata        = res_q.rdata;

endmodule
